### hw/rtl/prq_pkg.sv
package prq_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam logic [15:0] MEM_TOTAL_RESET = 16'd40960;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_RUN    = 2'd1,
        OP_SETPRI = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOTFOUND = 2'd1,
        ST_NOMEM    = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    // one table entry as held in the entry memory
    typedef struct packed {
        logic [15:0] id;
        logic [7:0]  prio;
        logic [15:0] mem;
        logic [15:0] rtime;
        logic [31:0] qstamp;
        logic [31:0] cstamp;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        status_t     status;
        logic [15:0] result_id;
        logic [15:0] time_left;
        logic        finished;
        logic [15:0] free_memory;
    } result_t;

endpackage

### hw/rtl/priority_run_queue_scheduler.sv
// Priority run queue scheduler.
// Request channel: req_valid/req_stall carry one word (opcode, task_id,
// priority_req, memory_request, run_time); it is taken on a clock edge with
// req_valid high and req_stall low. Response channel: rsp_valid/rsp_stall
// carry one word per request (status, result_id, time_left, finished,
// free_memory), held stable while rsp_stall is high.
// Each request scans every table entry from the entry memory, one read per
// cycle, then writes an entry back where its operation changes one. A
// request is held off until the previous one has left its execute step;
// its response is registered as it leaves that step. The scan through the
// single read port of the entry memory sets how long a request takes.
// A pending response does not block the next request; that request waits
// in its execute step only while the previous response is still stalled.
// The user must write memory_total via cfg_we/cfg_wdata while the block
// is idle (not enforced); it takes effect at once on the free memory figure.
// Reset (rst_n, asynchronous, active low) clears every entry valid bit,
// sets the next pid to 1, the stamp counter to 0 and memory_total to 40960.
module priority_run_queue_scheduler #(
    parameter int TABLE_DEPTH = prq_pkg::TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] task_id,
    input  logic [7:0]  priority_req,
    input  logic [15:0] memory_request,
    input  logic [15:0] run_time,
    output logic        rsp_valid,
    input  logic        rsp_stall,
    output logic [1:0]  status,
    output logic [15:0] result_id,
    output logic [15:0] time_left,
    output logic        finished,
    output logic [15:0] free_memory,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata
);
    import prq_pkg::*;

    logic [15:0] total_reg;
    logic        rsp_valid_reg;
    result_t     rsp_reg;
    result_t     res;
    logic        res_valid;
    logic        res_ready;

    assign res_ready = !rsp_valid_reg || !rsp_stall;

    prq_core #(.TABLE_DEPTH(TABLE_DEPTH)) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .req_valid      (req_valid),
        .req_stall      (req_stall),
        .opcode         (opcode),
        .task_id        (task_id),
        .priority_req   (priority_req),
        .memory_request (memory_request),
        .run_time       (run_time),
        .memory_total   (total_reg),
        .res_ready      (res_ready),
        .res_valid      (res_valid),
        .res            (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg     <= MEM_TOTAL_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                total_reg <= cfg_wdata;
            if (res_valid)
                rsp_valid_reg <= 1'b1;
            else if (!rsp_stall)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid)
            rsp_reg <= res;
    end

    assign rsp_valid   = rsp_valid_reg;
    assign status      = rsp_reg.status;
    assign result_id   = rsp_reg.result_id;
    assign time_left   = rsp_reg.time_left;
    assign finished    = rsp_reg.finished;
    assign free_memory = rsp_reg.free_memory;

endmodule

### hw/rtl/prq_mem.sv
module prq_mem #(
    parameter int DEPTH = prq_pkg::TABLE_DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          we,
    input  logic [$clog2(DEPTH)-1:0]      waddr,
    input  prq_pkg::entry_t               wdata,
    input  logic [$clog2(DEPTH)-1:0]      raddr,
    output prq_pkg::entry_t               rdata
);
    import prq_pkg::*;

    entry_t mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

### hw/rtl/prq_core.sv
module prq_core #(
    parameter int TABLE_DEPTH = prq_pkg::TABLE_DEPTH_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_stall,
    input  logic [1:0]        opcode,
    input  logic [15:0]       task_id,
    input  logic [7:0]        priority_req,
    input  logic [15:0]       memory_request,
    input  logic [15:0]       run_time,
    input  logic [15:0]       memory_total,
    input  logic              res_ready,
    output logic              res_valid,
    output prq_pkg::result_t  res
);
    import prq_pkg::*;

    localparam int IDX_W  = $clog2(TABLE_DEPTH);
    localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
    localparam int HELD_W = 16 + $clog2(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TABLE_DEPTH);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EXEC = 3'b100
    } state_t;

    state_t               state_reg, state_next;
    op_t                  op_reg;
    logic [15:0]          tid_reg, mreq_reg, rtime_reg;
    logic [7:0]           prio_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 pend_reg;
    logic [IDX_W-1:0]     pidx_reg;
    logic                 found_reg;
    logic [IDX_W-1:0]     bidx_reg;
    entry_t               best_reg;
    logic [31:0]          bqs_reg;
    logic                 ff_found_reg;
    logic [IDX_W-1:0]     ff_idx_reg;
    logic [TABLE_DEPTH-1:0] valid_reg, valid_next;
    logic [TABLE_DEPTH-1:0] rq_reg, rq_next;   // entry was requeued since its last rebuild
    logic [HELD_W-1:0]    held_reg, held_next;
    logic [31:0]          stamp_reg, stamp_next;
    logic [15:0]          nid_reg, nid_next;

    entry_t               rdata;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    entry_t               mem_wdata;

    logic                 cur_v;
    logic [31:0]          cur_qs;
    logic                 take_head, take_pid, take;
    logic [15:0]          free_now;
    logic [15:0]          tnew;
    logic                 exec_go;

    function automatic logic [15:0] calc_free(input logic [HELD_W-1:0] held,
                                              input logic [15:0] total);
        logic [HELD_W-1:0] tot_ext;
        tot_ext = HELD_W'(total);
        if (held >= tot_ext)
            return 16'd0;
        else
            return 16'(tot_ext - held);
    endfunction

    prq_mem #(.DEPTH(TABLE_DEPTH)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (cnt_reg[IDX_W-1:0]),
        .rdata (rdata)
    );

    assign req_stall = (state_reg != S_IDLE);
    assign exec_go   = (state_reg == S_EXEC) && res_ready;

    // scan compare on the entry read in the cycle before
    always_comb
    begin
        cur_v     = valid_reg[pidx_reg];
        cur_qs    = rq_reg[pidx_reg] ? rdata.qstamp : rdata.cstamp;
        take_head = cur_v && (!found_reg || rdata.prio < best_reg.prio ||
                    (rdata.prio == best_reg.prio && cur_qs < bqs_reg));
        take_pid  = cur_v && rdata.id == tid_reg &&
                    (!found_reg || rdata.cstamp < best_reg.cstamp);
        take      = (op_reg == OP_RUN) ? take_head : take_pid;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (cnt_reg == CNT_END && !pend_reg)
                    state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        free_now   = calc_free(held_reg, memory_total);
        tnew       = (best_reg.rtime != 16'd0) ? best_reg.rtime - 16'd1 : 16'd0;
        valid_next = valid_reg;
        rq_next    = rq_reg;
        held_next  = held_reg;
        stamp_next = stamp_reg;
        nid_next   = nid_reg;
        mem_we     = 1'b0;
        mem_waddr  = bidx_reg;
        mem_wdata  = best_reg;
        res        = '0;
        res.status = ST_OK;
        case (op_reg)
            OP_INSERT:
            begin
                if (mreq_reg > free_now)
                    res.status = ST_NOMEM;
                else if (!ff_found_reg)
                    res.status = ST_FULL;
                else
                begin
                    mem_we                = 1'b1;
                    mem_waddr             = ff_idx_reg;
                    mem_wdata.id          = nid_reg;
                    mem_wdata.prio        = prio_reg;
                    mem_wdata.mem         = mreq_reg;
                    mem_wdata.rtime       = rtime_reg;
                    mem_wdata.qstamp      = stamp_reg;
                    mem_wdata.cstamp      = stamp_reg;
                    valid_next[ff_idx_reg] = 1'b1;
                    rq_next[ff_idx_reg]    = 1'b0;
                    held_next             = held_reg + HELD_W'(mreq_reg);
                    stamp_next            = stamp_reg + 32'd1;
                    nid_next              = nid_reg + 16'd1;
                    res.result_id         = nid_reg;
                end
            end
            OP_RUN:
            begin
                if (!found_reg)
                    res.status = ST_NOTFOUND;
                else
                begin
                    res.result_id = best_reg.id;
                    res.time_left = tnew;
                    if (tnew != 16'd0)
                    begin
                        mem_we           = 1'b1;
                        mem_wdata.rtime  = tnew;
                        mem_wdata.qstamp = stamp_reg;
                        rq_next[bidx_reg] = 1'b1;
                        stamp_next       = stamp_reg + 32'd1;
                    end
                    else
                    begin
                        valid_next[bidx_reg] = 1'b0;
                        held_next            = held_reg - HELD_W'(best_reg.mem);
                        res.finished         = 1'b1;
                    end
                end
            end
            OP_SETPRI:
            begin
                if (!found_reg)
                    res.status = ST_NOTFOUND;
                else
                begin
                    mem_we         = 1'b1;
                    mem_wdata.prio = prio_reg;
                    rq_next        = '0;
                end
            end
            default:
            begin
                if (!found_reg)
                    res.status = ST_NOTFOUND;
                else
                begin
                    valid_next[bidx_reg] = 1'b0;
                    held_next            = held_reg - HELD_W'(best_reg.mem);
                    rq_next              = '0;
                end
            end
        endcase
        res.free_memory = calc_free(held_next, memory_total);
        if (!exec_go)
            mem_we = 1'b0;
    end

    assign res_valid = exec_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
            valid_reg <= '0;
            rq_reg    <= '0;
            held_reg  <= '0;
            stamp_reg <= '0;
            nid_reg   <= 16'd1;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= (state_reg == S_SCAN) && (cnt_reg != CNT_END);
            if (state_reg == S_IDLE)
                cnt_reg <= '0;
            else if (state_reg == S_SCAN && cnt_reg != CNT_END)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (exec_go)
            begin
                valid_reg <= valid_next;
                rq_reg    <= rq_next;
                held_reg  <= held_next;
                stamp_reg <= stamp_next;
                nid_reg   <= nid_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pidx_reg <= cnt_reg[IDX_W-1:0];
        if (state_reg == S_IDLE)
        begin
            op_reg       <= op_t'(opcode);
            tid_reg      <= task_id;
            prio_reg     <= priority_req;
            mreq_reg     <= memory_request;
            rtime_reg    <= run_time;
            found_reg    <= 1'b0;
            ff_found_reg <= 1'b0;
        end
        else if (pend_reg)
        begin
            if (take)
            begin
                found_reg <= 1'b1;
                bidx_reg  <= pidx_reg;
                best_reg  <= rdata;
                bqs_reg   <= cur_qs;
            end
            if (!cur_v && !ff_found_reg)
            begin
                ff_found_reg <= 1'b1;
                ff_idx_reg   <= pidx_reg;
            end
        end
    end

    a_we_exec: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> state_reg == S_EXEC)
        else $error("entry write outside execute");

    a_fin_ok: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.finished |-> res.status == ST_OK && res.time_left == 16'd0)
        else $error("finished word with bad status or time");

    a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> state_reg == S_SCAN && cnt_reg == '0)
        else $error("accepted word did not start a scan");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_END)
        else $error("scan counter out of range");

endmodule

### tb/prq_checker.sv
`timescale 1ns / 100ps

module prq_checker #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    input  logic        req_stall,
    input  logic [1:0]  opcode,
    input  logic [15:0] task_id,
    input  logic [7:0]  priority_req,
    input  logic [15:0] memory_request,
    input  logic [15:0] run_time,
    input  logic        rsp_valid,
    input  logic        rsp_stall,
    input  logic [1:0]  status,
    input  logic [15:0] result_id,
    input  logic [15:0] time_left,
    input  logic        finished,
    input  logic [15:0] free_memory,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          fail_count,
    output int          pending
);
    import prq_pkg::*;

    // scheduler shadow state
    logic [15:0] mem_total;
    logic        valid_q [DEPTH];
    logic [15:0] pid_q [DEPTH];
    logic [7:0]  prio_q [DEPTH];
    logic [15:0] held_q [DEPTH];
    logic [15:0] left_q [DEPTH];
    logic [31:0] qstamp_q [DEPTH];
    logic [31:0] cstamp_q [DEPTH];
    logic [31:0] stamp_now;
    logic [15:0] pid_next;
    logic [15:0] free_now;

    result_t expected_q[$];

    assign pending = expected_q.size();

    function automatic void refresh_free();
        logic [31:0] held;
        held = 0;
        for (int i = 0; i < DEPTH; i++)
            if (valid_q[i])
                held += held_q[i];
        free_now = (held >= mem_total) ? 16'd0 : 16'(mem_total - held);
    endfunction

    function automatic int oldest_pid(logic [15:0] pid);
        int hit;
        hit = -1;
        for (int i = 0; i < DEPTH; i++)
            if (valid_q[i] && pid_q[i] == pid &&
                (hit < 0 || cstamp_q[i] < cstamp_q[hit]))
                hit = i;
        return hit;
    endfunction

    function automatic void requeue_by_creation();
        for (int i = 0; i < DEPTH; i++)
            if (valid_q[i])
                qstamp_q[i] = cstamp_q[i];
    endfunction

    function automatic result_t schedule_op(op_t op, logic [15:0] pid, logic [7:0] prio,
                                            logic [15:0] need, logic [15:0] steps);
        result_t r;
        int slot;
        r = '0;
        r.status = ST_OK;
        slot = -1;
        case (op)
            OP_INSERT:
            begin
                if (need > free_now)
                    r.status = ST_NOMEM;
                else
                begin
                    for (int i = 0; i < DEPTH; i++)
                        if (!valid_q[i] && slot < 0)
                            slot = i;
                    if (slot < 0)
                        r.status = ST_FULL;
                    else
                    begin
                        valid_q[slot] = 1'b1;
                        pid_q[slot] = pid_next;
                        prio_q[slot] = prio;
                        held_q[slot] = need;
                        left_q[slot] = steps;
                        cstamp_q[slot] = stamp_now;
                        qstamp_q[slot] = stamp_now;
                        stamp_now++;
                        r.result_id = pid_next;
                        pid_next++;
                        refresh_free();
                    end
                end
            end
            OP_RUN:
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (valid_q[i] && (slot < 0 || prio_q[i] < prio_q[slot] ||
                        (prio_q[i] == prio_q[slot] && qstamp_q[i] < qstamp_q[slot])))
                        slot = i;
                if (slot < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    if (left_q[slot] != 0)
                        left_q[slot]--;
                    r.result_id = pid_q[slot];
                    r.time_left = left_q[slot];
                    if (left_q[slot] != 0)
                    begin
                        qstamp_q[slot] = stamp_now;
                        stamp_now++;
                    end
                    else
                    begin
                        valid_q[slot] = 1'b0;
                        r.finished = 1'b1;
                        refresh_free();
                    end
                end
            end
            default:
            begin
                slot = oldest_pid(pid);
                if (slot < 0)
                    r.status = ST_NOTFOUND;
                else
                begin
                    if (op == OP_SETPRI)
                        prio_q[slot] = prio;
                    else
                    begin
                        valid_q[slot] = 1'b0;
                        refresh_free();
                    end
                    requeue_by_creation();
                end
            end
        endcase
        r.free_memory = free_now;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        result_t exp_r;
        if (!rst_n)
        begin
            mem_total = MEM_TOTAL_RESET;
            for (int i = 0; i < DEPTH; i++)
                valid_q[i] = 1'b0;
            stamp_now = 0;
            pid_next = 16'd1;
            free_now = MEM_TOTAL_RESET;
            expected_q.delete();
            fail_count = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                mem_total = cfg_wdata;
                refresh_free();
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("unexpected result word");
                    fail_count++;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (status !== exp_r.status)
                    begin
                        $error("status exp %0d got %0d", exp_r.status, status);
                        fail_count++;
                    end
                    if (result_id !== exp_r.result_id)
                    begin
                        $error("result_id exp %0d got %0d", exp_r.result_id, result_id);
                        fail_count++;
                    end
                    if (time_left !== exp_r.time_left)
                    begin
                        $error("time_left exp %0d got %0d", exp_r.time_left, time_left);
                        fail_count++;
                    end
                    if (finished !== exp_r.finished)
                    begin
                        $error("finished exp %0d got %0d", exp_r.finished, finished);
                        fail_count++;
                    end
                    if (free_memory !== exp_r.free_memory)
                    begin
                        $error("free_memory exp %0d got %0d", exp_r.free_memory,
                               free_memory);
                        fail_count++;
                    end
                end
            end
            if (req_valid && !req_stall)
                expected_q.push_back(schedule_op(op_t'(opcode), task_id, priority_req,
                                                 memory_request, run_time));
        end
    end

endmodule

### tb/priority_run_queue_scheduler_tb.sv
`timescale 1ns / 100ps

module priority_run_queue_scheduler_tb;
    import prq_pkg::*;

    localparam int DEPTH = 16;
    localparam int CYCLE_LIMIT = 400000;

    logic        clk;
    logic        rst_n;
    logic        req_valid;
    logic        req_stall;
    logic [1:0]  opcode;
    logic [15:0] task_id;
    logic [7:0]  priority_req;
    logic [15:0] memory_request;
    logic [15:0] run_time;
    logic        rsp_valid;
    logic        rsp_stall;
    logic [1:0]  status;
    logic [15:0] result_id;
    logic [15:0] time_left;
    logic        finished;
    logic [15:0] free_memory;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    int          fail_count;
    int          pending;
    int          cycles;
    int          last_pid;

    priority_run_queue_scheduler #(.TABLE_DEPTH(DEPTH)) dut (.*);

    prq_checker #(.DEPTH(DEPTH)) checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // track the last pid returned in a response so set priority and remove mostly hit
    always @(posedge clk)
        if (rsp_valid && !rsp_stall && status == ST_OK && result_id != 0)
            last_pid <= result_id;

    // receiver: random stall length per word
    initial
    begin
        int n;
        rsp_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 3);
            repeat (n)
            begin
                rsp_stall <= 1'b1;
                @(posedge clk);
            end
            rsp_stall <= 1'b0;
            @(posedge clk);
            while (!rsp_valid)
                @(posedge clk);
        end
    end

    task automatic send_word(op_t op, logic [15:0] pid, logic [7:0] prio,
                             logic [15:0] need, logic [15:0] steps, bit allow_gap);
        int gap;
        gap = allow_gap ? $urandom_range(0, 3) : 0;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid <= 1'b1;
        opcode <= op;
        task_id <= pid;
        priority_req <= prio;
        memory_request <= need;
        run_time <= steps;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic drain_and_write(logic [15:0] total);
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= total;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_word(bit gaps);
        int pick;
        logic [15:0] pid;
        logic [15:0] need;
        logic [15:0] steps;
        pick = $urandom_range(0, 99);
        pid = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
              16'(last_pid - $urandom_range(0, 20));
        need = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3000));
        steps = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4));
        if (pick < 40)
            send_word(OP_INSERT, 16'($urandom), 8'($urandom_range(0, 3) == 0 ? $urandom :
                      $urandom_range(0, 3)), need, steps, gaps);
        else if (pick < 75)
            send_word(OP_RUN, 16'($urandom), 8'($urandom), 16'($urandom), 16'($urandom), gaps);
        else if (pick < 88)
            send_word(OP_SETPRI, pid, 8'($urandom_range(0, 3) == 0 ? $urandom :
                      $urandom_range(0, 3)), 16'($urandom), 16'($urandom), gaps);
        else
            send_word(OP_REMOVE, pid, 8'($urandom), 16'($urandom), 16'($urandom), gaps);
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_valid = 1'b0;
        opcode = OP_INSERT;
        task_id = '0;
        priority_req = '0;
        memory_request = '0;
        run_time = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        last_pid = 1;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty queue, unknown pid, memory limit, zero run time, full table
        send_word(OP_RUN, 16'd0, 8'd0, 16'd0, 16'd0, 0);
        send_word(OP_SETPRI, 16'd5, 8'd1, 16'd0, 16'd0, 0);
        send_word(OP_REMOVE, 16'hFFFF, 8'd0, 16'd0, 16'd0, 0);
        send_word(OP_INSERT, 16'd0, 8'd0, 16'hFFFF, 16'd1, 0);
        send_word(OP_INSERT, 16'd0, 8'hFF, 16'd0, 16'd0, 0);
        send_word(OP_RUN, 16'd0, 8'd0, 16'd0, 16'd0, 0);
        for (int i = 0; i < DEPTH + 1; i++)
            send_word(OP_INSERT, 16'd0, 8'(i % 3), 16'd100, (i == 0) ? 16'hFFFF : 16'd2, 0);
        send_word(OP_RUN, 16'd0, 8'd0, 16'd0, 16'd0, 0);
        send_word(OP_SETPRI, 16'd3, 8'd0, 16'd0, 16'd0, 0);
        send_word(OP_REMOVE, 16'd4, 8'd0, 16'd0, 16'd0, 0);

        drain_and_write(16'd0);
        for (int i = 0; i < 30; i++)
            random_word(1);
        drain_and_write(16'hFFFF);
        for (int i = 0; i < 600; i++)
            random_word(i % 200 < 150);
        drain_and_write(16'd5000);
        for (int i = 0; i < 550; i++)
            random_word(1);
        drain_and_write(16'd40960);
        for (int i = 0; i < 550; i++)
            random_word(i % 100 > 20);

        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DEPTH + 8) @(posedge clk);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
